@@ rtl/sparse_triplet_merge_add_core_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the sparse triplet merge-add core
// Same-cycle and next-cycle implication checks, reset-qualified.
// ----------------------------------------------------------------------------
`ifndef SPARSE_TRIPLET_MERGE_ADD_CORE_DEFINES_SVH
`define SPARSE_TRIPLET_MERGE_ADD_CORE_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define STMA_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define STMA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/stma_pkg.sv @@
// ----------------------------------------------------------------------------
// stma_pkg
// Shared types and constants of the sparse triplet merge-add core.
// ----------------------------------------------------------------------------
`default_nettype none

package stma_pkg;

    localparam int LIST_DEPTH = 32;
    localparam int ADDR_W     = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

    // list fill count at which further loads are dropped
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(LIST_DEPTH);

    // action codes
    localparam logic [1:0] ACT_LOAD_A = 2'd0;
    localparam logic [1:0] ACT_LOAD_B = 2'd1;
    localparam logic [1:0] ACT_START  = 2'd2;

    typedef struct packed {
        logic [7:0]         row;
        logic [7:0]         col;
        logic signed [15:0] value;
    } entry_t;

    // top -> merge sequencer
    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] cnt_a;
        logic [CNT_W-1:0] cnt_b;
        logic             ovf;
    } merge_ctl_t;

    // merge sequencer -> top
    typedef struct packed {
        logic busy;
        logic done;
    } merge_sts_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_MERGE = 2'b10
    } merge_state_t;

endpackage

`default_nettype wire

@@ rtl/stma_list_ram.sv @@
// ----------------------------------------------------------------------------
// stma_list_ram
// One entry list: single write port, registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module stma_list_ram (
    input  wire logic                        aclk,
    input  wire logic                        we,
    input  wire logic [stma_pkg::ADDR_W-1:0] waddr,
    input  wire stma_pkg::entry_t            wdata,
    input  wire logic [stma_pkg::ADDR_W-1:0] raddr,
    output stma_pkg::entry_t                 rdata
);

    stma_pkg::entry_t mem [stma_pkg::LIST_DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ rtl/stma_merge.sv @@
// ----------------------------------------------------------------------------
// stma_merge
// Two-head merge sequencer with output register.
// ----------------------------------------------------------------------------
`default_nettype none

module stma_merge (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire stma_pkg::merge_ctl_t        ctl,
    output stma_pkg::merge_sts_t             sts,
    input  wire stma_pkg::entry_t            head_a,
    input  wire stma_pkg::entry_t            head_b,
    output logic [stma_pkg::ADDR_W-1:0]      raddr_a,
    output logic [stma_pkg::ADDR_W-1:0]      raddr_b,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [7:0]                       m_out_row,
    output logic [7:0]                       m_out_col,
    output logic signed [16:0]               m_out_value,
    output logic                             m_empty_res,
    output logic                             m_overflowed,
    output logic                             m_last
);

    stma_pkg::merge_state_t state_reg, state_next;
    logic [stma_pkg::CNT_W-1:0] ia_reg, ia_next, ib_reg, ib_next;
    logic valid_reg, valid_next;
    logic [7:0] row_reg, row_next, col_reg, col_next;
    logic signed [16:0] val_reg, val_next;
    logic empty_reg, empty_next, ovf_reg, ovf_next, last_reg, last_next;

    logic        a_done, b_done, can_emit, take_a, take_b, done;
    logic [15:0] key_a, key_b;
    logic signed [16:0] va, vb;

    always_comb begin
        a_done   = (ia_reg >= ctl.cnt_a);
        b_done   = (ib_reg >= ctl.cnt_b);
        key_a    = {head_a.row, head_a.col};
        key_b    = {head_b.row, head_b.col};
        va       = 17'(head_a.value);
        vb       = 17'(head_b.value);
        take_a   = b_done || (!a_done && (key_a < key_b));
        take_b   = !take_a && (a_done || (key_b < key_a));
        can_emit = (state_reg == stma_pkg::ST_MERGE) && (!valid_reg || m_ready);

        state_next = state_reg;
        ia_next    = ia_reg;
        ib_next    = ib_reg;
        valid_next = valid_reg && !m_ready;
        row_next   = row_reg;
        col_next   = col_reg;
        val_next   = val_reg;
        empty_next = empty_reg;
        ovf_next   = ovf_reg;
        last_next  = last_reg;
        done       = 1'b0;

        unique case (state_reg)
            stma_pkg::ST_IDLE: begin
                ia_next = '0;
                ib_next = '0;
                if (ctl.start) begin
                    state_next = stma_pkg::ST_MERGE;
                end
            end
            stma_pkg::ST_MERGE: begin
                if (can_emit) begin
                    valid_next = 1'b1;
                    ovf_next   = ctl.ovf;
                    if (a_done && b_done) begin
                        // both lists empty
                        row_next   = '0;
                        col_next   = '0;
                        val_next   = '0;
                        empty_next = 1'b1;
                        last_next  = 1'b1;
                        done       = 1'b1;
                    end else begin
                        empty_next = 1'b0;
                        if (take_a) begin
                            row_next = head_a.row;
                            col_next = head_a.col;
                            val_next = va;
                            ia_next  = ia_reg + stma_pkg::CNT_W'(1);
                        end else if (take_b) begin
                            row_next = head_b.row;
                            col_next = head_b.col;
                            val_next = vb;
                            ib_next  = ib_reg + stma_pkg::CNT_W'(1);
                        end else begin
                            row_next = head_a.row;
                            col_next = head_a.col;
                            val_next = va + vb;
                            ia_next  = ia_reg + stma_pkg::CNT_W'(1);
                            ib_next  = ib_reg + stma_pkg::CNT_W'(1);
                        end
                        last_next = (ia_next >= ctl.cnt_a) && (ib_next >= ctl.cnt_b);
                        done      = last_next;
                    end
                    if (done) begin
                        state_next = stma_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = stma_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= stma_pkg::ST_IDLE;
            ia_reg    <= '0;
            ib_reg    <= '0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            ia_reg    <= ia_next;
            ib_reg    <= ib_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        row_reg   <= row_next;
        col_reg   <= col_next;
        val_reg   <= val_next;
        empty_reg <= empty_next;
        ovf_reg   <= ovf_next;
        last_reg  <= last_next;
    end

    // read the next heads; the registered RAM returns the data in the next cycle
    assign raddr_a = ia_next[stma_pkg::ADDR_W-1:0];
    assign raddr_b = ib_next[stma_pkg::ADDR_W-1:0];

    assign sts.busy = (state_reg == stma_pkg::ST_MERGE);
    assign sts.done = done;

    assign m_valid      = valid_reg;
    assign m_out_row    = row_reg;
    assign m_out_col    = col_reg;
    assign m_out_value  = val_reg;
    assign m_empty_res  = empty_reg;
    assign m_overflowed = ovf_reg;
    assign m_last       = last_reg;

endmodule

`default_nettype wire

@@ rtl/sparse_triplet_merge_add_core.sv @@
// ----------------------------------------------------------------------------
// sparse_triplet_merge_add_core
// Adds two sparse matrices held as sorted (row, col, value) lists.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  s_      | in  | s_valid / s_ready  | action, row, col, value
//  m_      | out | m_valid / m_ready  | out_row, out_col, out_value, empty_res,
//          |     |                    | overflowed, last
//
//  Loads are accepted back to back.
//  A start runs the merge: one result per cycle out of the two list RAMs
//  while m_ready is high, each head re-read every cycle.
//  s_ready is low while a merge runs; m_ready low stalls it with a result held.
//  Reset (aresetn, synchronous) empties both lists and clears the overflow
//  flag; list RAM contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module sparse_triplet_merge_add_core (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_action,
    input  wire logic [7:0]         s_row,
    input  wire logic [7:0]         s_col,
    input  wire logic signed [15:0] s_value,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [7:0]              m_out_row,
    output logic [7:0]              m_out_col,
    output logic signed [16:0]      m_out_value,
    output logic                    m_empty_res,
    output logic                    m_overflowed,
    output logic                    m_last
);

    logic [stma_pkg::CNT_W-1:0] cnt_a_reg, cnt_a_next, cnt_b_reg, cnt_b_next;
    logic ovf_reg, ovf_next;

    logic acc, load_a, load_b, we_a, we_b;
    stma_pkg::entry_t wentry, head_a, head_b;
    logic [stma_pkg::ADDR_W-1:0] raddr_a, raddr_b;
    stma_pkg::merge_ctl_t ctl;
    stma_pkg::merge_sts_t sts;

    assign s_ready = !sts.busy;
    assign acc     = s_valid && s_ready;
    assign load_a  = acc && (s_action == stma_pkg::ACT_LOAD_A);
    assign load_b  = acc && (s_action == stma_pkg::ACT_LOAD_B);
    // a load into a full list is dropped
    assign we_a    = load_a && (cnt_a_reg < stma_pkg::DEPTH_CNT);
    assign we_b    = load_b && (cnt_b_reg < stma_pkg::DEPTH_CNT);

    assign wentry.row   = s_row;
    assign wentry.col   = s_col;
    assign wentry.value = s_value;

    always_comb begin
        cnt_a_next = cnt_a_reg;
        cnt_b_next = cnt_b_reg;
        ovf_next   = ovf_reg;
        if (sts.done) begin
            // run finished: both lists are empty again
            cnt_a_next = '0;
            cnt_b_next = '0;
            ovf_next   = 1'b0;
        end else begin
            if (we_a) begin
                cnt_a_next = cnt_a_reg + stma_pkg::CNT_W'(1);
            end
            if (we_b) begin
                cnt_b_next = cnt_b_reg + stma_pkg::CNT_W'(1);
            end
            if ((load_a && !we_a) || (load_b && !we_b)) begin
                ovf_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_a_reg <= '0;
            cnt_b_reg <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            cnt_a_reg <= cnt_a_next;
            cnt_b_reg <= cnt_b_next;
            ovf_reg   <= ovf_next;
        end
    end

    assign ctl.start = acc && (s_action == stma_pkg::ACT_START);
    assign ctl.cnt_a = cnt_a_reg;
    assign ctl.cnt_b = cnt_b_reg;
    assign ctl.ovf   = ovf_reg;

    stma_list_ram u_list_a (
        .aclk  (aclk),
        .we    (we_a),
        .waddr (cnt_a_reg[stma_pkg::ADDR_W-1:0]),
        .wdata (wentry),
        .raddr (raddr_a),
        .rdata (head_a)
    );

    stma_list_ram u_list_b (
        .aclk  (aclk),
        .we    (we_b),
        .waddr (cnt_b_reg[stma_pkg::ADDR_W-1:0]),
        .wdata (wentry),
        .raddr (raddr_b),
        .rdata (head_b)
    );

    stma_merge u_merge (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctl          (ctl),
        .sts          (sts),
        .head_a       (head_a),
        .head_b       (head_b),
        .raddr_a      (raddr_a),
        .raddr_b      (raddr_b),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_row    (m_out_row),
        .m_out_col    (m_out_col),
        .m_out_value  (m_out_value),
        .m_empty_res  (m_empty_res),
        .m_overflowed (m_overflowed),
        .m_last       (m_last)
    );

endmodule

`default_nettype wire

@@ rtl/stma_checker.sv @@
// ----------------------------------------------------------------------------
// stma_checker
// Port-level assertions for the sparse triplet merge-add core.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sparse_triplet_merge_add_core_defines.svh"

module stma_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_valid,
    input wire logic               s_ready,
    input wire logic [1:0]         s_action,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire logic [7:0]         m_out_row,
    input wire logic [7:0]         m_out_col,
    input wire logic signed [16:0] m_out_value,
    input wire logic               m_empty_res,
    input wire logic               m_overflowed,
    input wire logic               m_last
);

    logic        s_start;
    logic        m_stall;
    logic [35:0] m_payload;

    assign s_start   = s_valid && s_ready && (s_action == stma_pkg::ACT_START);
    assign m_stall   = m_valid && !m_ready;
    assign m_payload = {m_out_row, m_out_col, m_out_value, m_empty_res,
                        m_overflowed, m_last};

    `STMA_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_stall, m_valid && $stable(m_payload), "stalled result moved")
    `STMA_ASSERT_NOW(a_empty_last, aclk, aresetn, m_valid && m_empty_res, m_last, "empty result not marked last")
    `STMA_ASSERT_NOW(a_empty_zero, aclk, aresetn, m_valid && m_empty_res, (m_out_row == 8'd0) && (m_out_col == 8'd0) && (m_out_value == 17'sd0), "empty result carries data")
    `STMA_ASSERT_NEXT(a_start_busy, aclk, aresetn, s_start, !s_ready, "input taken right after a start")

endmodule

bind sparse_triplet_merge_add_core stma_checker u_stma_checker (.*);

`default_nettype wire
